// File: rtl/rzs_pkg.sv
// Shared constants and result codes for the row z-score normalizer.
package rzs_pkg;

  localparam int MAX_COLS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int Z_W      = 32;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_NORM = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PASS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVFL = 2'd3;

endpackage

// File: rtl/rzs_zcalc.sv
// Bit-serial restoring divider followed by a bit-serial integer square root.
module rzs_zcalc #(
  parameter int SQ_W      = 50,
  parameter int DEV_W     = 44,
  parameter int FRAC_BITS = 16,
  parameter int QW        = 38
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQ_W-1:0]    dividend,
  input  logic [DEV_W-1:0]   divisor,
  output logic               done,
  output logic [QW/2-1:0]    root
);

  localparam int DVD_W = SQ_W + 2 * FRAC_BITS;
  localparam int RW    = QW / 2;
  localparam int CW    = $clog2(DVD_W + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_SQRT = 2'd2;

  logic [1:0]       state;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] dsr;
  logic [DEV_W-1:0] rem;
  logic [DEV_W-1:0] dvs;
  logic [QW-1:0]    quot;
  logic [RW+1:0]    srem;
  logic [RW-1:0]    sroot;

  logic [DEV_W:0]   dtrial;
  logic [DEV_W:0]   ddiff;
  logic [RW+2:0]    strial;
  logic [RW+2:0]    stest;
  logic [RW+2:0]    sdiff;

  // One quotient bit per cycle: shift in the next dividend bit and try the subtract.
  assign dtrial = {rem, dsr[DVD_W-1]};
  assign ddiff  = dtrial - {1'b0, dvs};
  // One root bit per cycle: bring down two radicand bits.
  assign stest  = {srem[RW:0], quot[QW-1:QW-2]};
  assign strial = {1'b0, sroot, 2'b01};
  assign sdiff  = stest - strial;

  assign root = sroot;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (start) begin
            dsr   <= {dividend, {(2 * FRAC_BITS){1'b0}}};
            dvs   <= divisor;
            rem   <= '0;
            quot  <= '0;
            cnt   <= CW'(DVD_W);
            state <= U_DIV;
          end
        end
        U_DIV: begin
          dsr <= {dsr[DVD_W-2:0], 1'b0};
          if (!ddiff[DEV_W]) begin
            rem  <= ddiff[DEV_W-1:0];
            quot <= {quot[QW-2:0], 1'b1};
          end else begin
            rem  <= dtrial[DEV_W-1:0];
            quot <= {quot[QW-2:0], 1'b0};
          end
          if (cnt == CW'(1)) begin
            srem  <= '0;
            sroot <= '0;
            cnt   <= CW'(RW);
            state <= U_SQRT;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        U_SQRT: begin
          quot <= {quot[QW-3:0], 2'b00};
          if (!sdiff[RW+2]) begin
            srem  <= sdiff[RW+1:0];
            sroot <= {sroot[RW-2:0], 1'b1};
          end else begin
            srem  <= stest[RW+1:0];
            sroot <= {sroot[RW-2:0], 1'b0};
          end
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/row_zscore_normalizer_core.sv
// Row z-score normalizer: row storage, accumulation and per-element result sequencing.
// Input: a stored element is accepted, squared and accumulated before the next is taken; a
// dropped element is only accepted. After the row's last element S_NQ and S_DEV form the
// deviation term; each result is then read, turned into a numerator and its square and fed
// to the bit-serial divider and square root; passed-through and zero rows skip them.
// Synchronous active-high reset clears all control state; stored row data is not cleared.
module row_zscore_normalizer_core #(
  parameter int MAX_COLS  = rzs_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = rzs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] z_value
  output logic [1:0]  m_tuser,   // [1:0] row_status
  output logic        m_tlast
);

  localparam int SW     = rzs_pkg::SAMPLE_W;
  localparam int ZW     = rzs_pkg::Z_W;
  localparam int LOGN   = $clog2(MAX_COLS);
  localparam int IDX_W  = (LOGN > 0) ? LOGN : 1;
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int SUM_W  = SW + 1 + LOGN;
  localparam int SQX_W  = 2 * SW - 1;
  localparam int QS_W   = SQX_W + LOGN;
  localparam int NQ_W   = CNT_W + QS_W;
  localparam int S2_W   = 2 * SUM_W;
  localparam int DEV_W  = NQ_W;
  localparam int NUM_W  = SUM_W + 2;
  localparam int SQ_W   = 2 * NUM_W;
  localparam int QW     = 2 * ((LOGN + 1) / 2) + 2 * FRAC_BITS;
  localparam int RW     = QW / 2;

  localparam logic [3:0] S_IN   = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_NQ   = 4'd3;
  localparam logic [3:0] S_DEV  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_NUM  = 4'd6;
  localparam logic [3:0] S_MAG  = 4'd7;
  localparam logic [3:0] S_GO   = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]                  state;
  logic [SW-1:0]               row_store [MAX_COLS];
  logic [SW-1:0]               mem_q;
  logic signed [SW-1:0]        x_reg;
  logic                        end_reg;
  logic signed [SUM_W-1:0]     running_sum;
  logic [QS_W-1:0]             square_sum;
  logic [CNT_W-1:0]            element_count;
  logic                        overflow_seen;
  logic [SQX_W-1:0]            sqx;
  logic [NQ_W-1:0]             nq;
  logic [S2_W-1:0]             s2;
  logic [DEV_W-1:0]            dev;
  logic [rzs_pkg::STATUS_W-1:0] status;
  logic [CNT_W-1:0]            k;
  logic signed [NUM_W-1:0]     num;
  logic [SQ_W-1:0]             mag2;
  logic                        neg;
  logic signed [ZW-1:0]        z;

  logic                        in_acc;
  logic                        room;
  logic signed [SW-1:0]        x_in;
  logic signed [SUM_W-1:0]     x_sum;
  logic signed [2*SW-1:0]      xx;
  logic [NQ_W-1:0]             nq_c;
  logic signed [S2_W-1:0]      s2_c;
  logic [S2_W-1:0]             dv;
  logic signed [CNT_W:0]       n_s;
  logic signed [SW-1:0]        e_s;
  logic signed [NUM_W-1:0]     ne;
  logic signed [NUM_W-1:0]     sum_x;
  logic signed [ZW-1:0]        e_z;
  logic [NUM_W-1:0]            mag;
  logic                        calc_done;
  logic [RW-1:0]               root;
  logic signed [ZW-1:0]        root_z;
  logic                        out_free;
  logic                        last_k;

  assign s_tready = (state == S_IN);
  assign in_acc   = s_tvalid && s_tready;
  assign room     = (element_count < CNT_W'(MAX_COLS));
  assign x_in     = s_tdata;
  assign x_sum    = SUM_W'(x_in);
  assign xx       = x_reg * x_reg;
  assign nq_c     = NQ_W'(element_count) * NQ_W'(square_sum);
  assign s2_c     = S2_W'(running_sum) * S2_W'(running_sum);
  assign dv       = S2_W'(nq) - s2;
  assign n_s      = {1'b0, element_count};
  assign e_s      = mem_q;
  assign ne       = NUM_W'(n_s) * NUM_W'(e_s);
  assign sum_x    = NUM_W'(running_sum);
  assign e_z      = ZW'(e_s);
  assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign root_z   = ZW'(root);
  assign out_free = !m_tvalid || m_tready;
  assign last_k   = (k + CNT_W'(1) == element_count);

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      row_store[element_count[IDX_W-1:0]] <= s_tdata;
    end
    if (state == S_RD) begin
      mem_q <= row_store[k[IDX_W-1:0]];
    end
  end

  rzs_zcalc #(
    .SQ_W      (SQ_W),
    .DEV_W     (DEV_W),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_zcalc (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_GO),
    .dividend (mag2),
    .divisor  (dev),
    .done     (calc_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IN;
      running_sum   <= '0;
      square_sum    <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
      k             <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // In S_OUT the valid flag is handled by the output load below.
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IN: begin
          if (in_acc) begin
            x_reg   <= x_in;
            end_reg <= s_tlast;
            if (room) begin
              running_sum   <= running_sum + x_sum;
              element_count <= element_count + CNT_W'(1);
              state         <= S_SQ;
            end else begin
              overflow_seen <= 1'b1;
              if (s_tlast) begin
                state <= S_NQ;
              end
            end
          end
        end
        S_SQ: begin
          sqx   <= xx[SQX_W-1:0];
          state <= S_ACC;
        end
        S_ACC: begin
          square_sum <= square_sum + QS_W'(sqx);
          state      <= end_reg ? S_NQ : S_IN;
        end
        S_NQ: begin
          nq    <= nq_c;
          s2    <= s2_c;
          state <= S_DEV;
        end
        S_DEV: begin
          dev <= dv[DEV_W-1:0];
          if (running_sum <= 0) begin
            status <= rzs_pkg::ST_PASS;
          end else if (dv[DEV_W-1:0] == '0) begin
            status <= rzs_pkg::ST_ZERO;
          end else begin
            status <= rzs_pkg::ST_NORM;
          end
          k     <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_NUM;
        end
        S_NUM: begin
          if (status == rzs_pkg::ST_PASS) begin
            z     <= e_z <<< FRAC_BITS;
            state <= S_OUT;
          end else if (status == rzs_pkg::ST_ZERO) begin
            z     <= '0;
            state <= S_OUT;
          end else begin
            num   <= ne - sum_x;
            state <= S_MAG;
          end
        end
        S_MAG: begin
          mag2  <= SQ_W'(mag) * SQ_W'(mag);
          neg   <= num[NUM_W-1];
          state <= S_GO;
        end
        S_GO: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (calc_done) begin
            z     <= neg ? -root_z : root_z;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= z;
            m_tuser  <= overflow_seen ? rzs_pkg::ST_OVFL : status;
            m_tlast  <= last_k;
            if (last_k) begin
              running_sum   <= '0;
              square_sum    <= '0;
              element_count <= '0;
              overflow_seen <= 1'b0;
              state         <= S_IN;
            end else begin
              k     <= k + CNT_W'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

// File: rtl/rzs_checker.sv
// Port-level checker for the row z-score normalizer, bound to the top level.
module rzs_checker #(
  parameter int FRAC_BITS = rzs_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A passed-through element is a whole number with an empty fraction.
  a_pass: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rzs_pkg::ST_PASS |-> m_tdata[FRAC_BITS-1:0] == '0)
    else $error("passed-through value has fraction bits");

  // A zero-deviation row reports zeros.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rzs_pkg::ST_ZERO |-> m_tdata == '0)
    else $error("zero-deviation row gave a nonzero value");

  // The request that ends a row is never followed directly by another request.
  a_end: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after end of row");

endmodule

bind row_zscore_normalizer_core rzs_checker #(.FRAC_BITS(FRAC_BITS)) u_rzs_checker (.*);

// File: dv/row_zscore_normalizer_core_test.sv
// Testbench for the row z-score normalizer: table-driven rows, then random rows, checked on the fly.
`timescale 1ns / 1ps
module row_zscore_normalizer_core_test;

  localparam int COLS = rzs_pkg::MAX_COLS_DEF;
  localparam int FRAC = rzs_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] z_value;
    logic [1:0]  row_status;
    logic        final_res;
  } zscore_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               row_end;
    logic               has_expect;
    zscore_t            expect_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  always #2 clk = ~clk;

  row_zscore_normalizer_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Predictor state for the row being collected.
  logic signed [15:0] row_copy [COLS];
  int  row_len;
  longint row_sum;
  longint row_sqsum;
  bit  row_over;

  zscore_t z_queue [$];
  int  fail_count = 0;
  int  results_seen = 0;
  int  rows_done = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned scaled_ratio(longint unsigned num2,
                                                   longint unsigned den);
    longint unsigned q, r;
    q = num2 / den;
    r = num2 % den;
    for (int i = 0; i < 2 * FRAC; i++) begin
      q <<= 1;
      r <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // Updates the row copy and, at a row end, queues the row's z-scores.
  task automatic predict_zscores(input logic signed [15:0] x, input logic last,
                                 input bit has_exp, input zscore_t exp_res);
    logic [1:0] status;
    longint unsigned dev, mag;
    longint num, z;
    zscore_t res;
    dev = 0;
    if (row_len < COLS) begin
      row_copy[row_len] = x;
      row_sum += x;
      row_sqsum += longint'(x) * longint'(x);
      row_len++;
    end else begin
      row_over = 1;
    end
    if (!last) return;
    if (row_sum <= 0) begin
      status = rzs_pkg::ST_PASS;
    end else begin
      dev = longint'(row_len) * row_sqsum - row_sum * row_sum;
      status = (dev == 0) ? rzs_pkg::ST_ZERO : rzs_pkg::ST_NORM;
    end
    for (int k = 0; k < row_len; k++) begin
      if (status == rzs_pkg::ST_PASS) z = longint'(row_copy[k]) <<< FRAC;
      else if (status == rzs_pkg::ST_ZERO) z = 0;
      else begin
        num = longint'(row_len) * row_copy[k] - row_sum;
        mag = num < 0 ? -num : num;
        z = int_sqrt(scaled_ratio(mag * mag, dev));
        if (num < 0) z = -z;
      end
      res.z_value = z[31:0];
      res.row_status = row_over ? rzs_pkg::ST_OVFL : status;
      res.final_res = (k + 1 == row_len);
      z_queue = {z_queue, res};
    end
    // A typed-in expectation applies to the last result of this row.
    if (has_exp && row_len > 0) z_queue[$] = exp_res;
    rows_done++;
    row_len = 0;
    row_sum = 0;
    row_sqsum = 0;
    row_over = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(99) < 32);
  endfunction

  // Result side: random backpressure and field-by-field compare.
  always @(posedge clk) begin
    zscore_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (z_queue.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 32'd0);
        end else begin
          want = z_queue.pop_front();
          if (m_tdata !== want.z_value) report_mismatch("z_value", m_tdata, want.z_value);
          if (m_tuser !== want.row_status)
            report_mismatch("row_status", 32'(m_tuser), 32'(want.row_status));
          if (m_tlast !== want.final_res)
            report_mismatch("final_res", 32'(m_tlast), 32'(want.final_res));
        end
        results_seen++;
      end
      m_tready <= !idle_now();
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The request stays valid after acceptance until the next one or a pause replaces it.
  task automatic send_request(input logic signed [15:0] x, input logic last,
                              input bit has_exp, input zscore_t exp_res);
    if (idle_now()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_zscores(x, last, has_exp, exp_res);
  endtask

  task automatic hold_requests();
    s_tvalid <= 1'b0;
  endtask

  task automatic send_row(input int len, input int mode);
    logic signed [15:0] x;
    zscore_t none;
    none = '0;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: x = 16'($urandom);
        1: x = 16'($urandom_range(2000) + 1);
        2: x = 16'sd37;
        default: x = 16'($urandom_range(255));
      endcase
      send_request(x, i == len - 1, 1'b0, none);
    end
  endtask

  stim_row_t directed [$];

  task automatic add_row(input logic signed [15:0] x, input logic last,
                         input bit has_exp = 0, input logic [31:0] zv = 0,
                         input logic [1:0] st = rzs_pkg::ST_NORM);
    stim_row_t r;
    r.sample = x;
    r.row_end = last;
    r.has_expect = has_exp;
    r.expect_res = '{zv, st, 1'b1};
    directed = {directed, r};
  endtask

  initial begin
    int len, pick;
    row_len = 0;
    row_sum = 0;
    row_sqsum = 0;
    row_over = 0;
    // One-element rows: passed through, zero deviation, extremes.
    add_row(16'sh7FFF, 1, 1, 32'h0, rzs_pkg::ST_ZERO);
    add_row(-16'sd32768, 1, 1, 32'h8000_0000, rzs_pkg::ST_PASS);
    add_row(16'sd0, 1, 1, 32'h0, rzs_pkg::ST_PASS);
    add_row(16'sd1, 1, 1, 32'h0, rzs_pkg::ST_ZERO);
    // Two-element normalized row: z values are -1 and +1.
    add_row(16'sd1, 0);
    add_row(16'sd3, 1, 1, 32'h0001_0000, rzs_pkg::ST_NORM);
    // Mixed-sign row whose sum is negative.
    add_row(-16'sd5, 0);
    add_row(16'sd2, 1, 1, 32'h0002_0000, rzs_pkg::ST_PASS);
    // Full-scale values in a normalized row.
    add_row(16'sh7FFF, 0);
    add_row(-16'sd32768, 0);
    add_row(16'sh7FFF, 0);
    add_row(16'sh5555, 1);
    add_row(-16'sd1, 0);
    add_row(16'sd1, 1, 1, 32'h0001_0000, rzs_pkg::ST_PASS);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].sample, directed[i].row_end, directed[i].has_expect,
                   directed[i].expect_res);

    // Overflowing row: one more than capacity, ending on a dropped element.
    send_row(COLS + 1, 1);
    // Full row of random full-range values.
    send_row(COLS, 0);

    // Sender waits until every result has arrived.
    hold_requests();
    while (z_queue.size() != 0) @(posedge clk);

    quiet_mode = 1;
    send_row(8, 1);
    send_row(5, 0);
    quiet_mode = 0;

    while (items_sent < 310) begin
      pick = $urandom_range(9);
      len = (pick == 0) ? $urandom_range(COLS + 3, 40) : $urandom_range(8, 1);
      send_row(len, (pick < 5) ? 1 : (pick < 8) ? 0 : (pick == 8) ? 2 : 3);
    end
    hold_requests();

    while (z_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d rows, %0d results: passed-through, zero-deviation, overflow,",
             rows_done, results_seen);
    $display("and normalized rows with random lengths and both-side stalls");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rzs_pkg.sv
rtl/rzs_zcalc.sv
rtl/row_zscore_normalizer_core.sv
rtl/rzs_checker.sv
dv/row_zscore_normalizer_core_test.sv
